@@ rtl/complex_frequency_shifter_assert.svh @@
// Assertion macros for the complex frequency shifter, checked on clk, disabled in reset.
`ifndef COMPLEX_FREQUENCY_SHIFTER_ASSERT_SVH
`define COMPLEX_FREQUENCY_SHIFTER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge out of reset
`define CFS_CHECK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("cfs assertion failed");

// Check that a condition never occurs out of reset
`define CFS_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("cfs forbidden condition");

`else

`define CFS_CHECK(label, prop)
`define CFS_NEVER(label, expr)

`endif

`endif

@@ rtl/cfs_pkg.sv @@
// Shared constants, types and table builder for the complex frequency shifter.
`timescale 1ns / 1ps

package cfs_pkg;

	// Default geometry
	localparam int SAMPLE_BITS_DEF     = 16;
	localparam int PHASE_BITS_DEF      = 32;
	localparam int TABLE_ADDR_BITS_DEF = 10;

	// Configuration port
	localparam int STEP_BITS      = 32;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 32;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PHASE_STEP = 1'b0,
		REG_KEEP_PHASE = 1'b1
	} cfs_reg_t;

	// Output queue sizing
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = 2;
	localparam int FIFO_LVL_BITS = 3;

	// Quadrant decode that travels with the table read data
	typedef struct packed {
		logic sin_neg;
		logic sin_full;
		logic cos_neg;
		logic cos_full;
	} cfs_quad_t;

	// Quarter-wave sine entry: Q30 Taylor series, rounded to the sample amplitude
	function automatic longint unsigned table_entry(input int unsigned k,
		input int tab_bits, input int sample_bits);
		longint unsigned one_q30;
		longint unsigned amp;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned v;
		one_q30 = 64'd1 << 30;
		amp = (64'd1 << (sample_bits - 1)) - 64'd1;
		x = (64'(k) * 64'd1686629713 + ((64'd1 << tab_bits) >> 1)) >> tab_bits;
		x2 = (x * x) >> 30;
		t = one_q30;
		t = one_q30 - ((x2 * t) >> 30) / 64'd272;
		t = one_q30 - ((x2 * t) >> 30) / 64'd210;
		t = one_q30 - ((x2 * t) >> 30) / 64'd156;
		t = one_q30 - ((x2 * t) >> 30) / 64'd110;
		t = one_q30 - ((x2 * t) >> 30) / 64'd72;
		t = one_q30 - ((x2 * t) >> 30) / 64'd42;
		t = one_q30 - ((x2 * t) >> 30) / 64'd20;
		t = one_q30 - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		v = (s * amp + (64'd1 << 29)) >> 30;
		if (v > amp) begin
			v = amp;
		end
		return v;
	endfunction

endpackage

@@ rtl/cfs_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module cfs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [ADDR_BITS-1:0] raddr_a,
	output logic [WIDTH-1:0]     rdata_a,
	input  logic [ADDR_BITS-1:0] raddr_b,
	output logic [WIDTH-1:0]     rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ rtl/cfs_nco.sv @@
// Oscillator: tuning registers, phase accumulator, sine table fill and lookup.
`timescale 1ns / 1ps

module cfs_nco #(
	parameter int SAMPLE_BITS     = cfs_pkg::SAMPLE_BITS_DEF,
	parameter int PHASE_BITS      = cfs_pkg::PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = cfs_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [cfs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [cfs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                adv,
	output logic                                fill_done,
	output logic [SAMPLE_BITS-2:0]              sin_mag_s1,
	output logic [SAMPLE_BITS-2:0]              cos_mag_s1,
	output cfs_pkg::cfs_quad_t                  quad_s1
);

	localparam int TAB_N    = 1 << TABLE_ADDR_BITS;
	localparam int IDX_BITS = TABLE_ADDR_BITS + 2;

	logic [PHASE_BITS-1:0]         phase_q;
	logic [cfs_pkg::STEP_BITS-1:0] step_q;
	logic                          keep_q;
	logic [PHASE_BITS-1:0]         step_scaled;
	logic [TABLE_ADDR_BITS:0]      fill_cnt_q;
	logic [IDX_BITS-1:0]           idx;
	logic [1:0]                    quad_sin;
	logic [1:0]                    quad_cos;
	logic [TABLE_ADDR_BITS-1:0]    addr_fwd;
	logic [TABLE_ADDR_BITS-1:0]    addr_rev;
	logic [TABLE_ADDR_BITS-1:0]    sin_addr;
	logic [TABLE_ADDR_BITS-1:0]    cos_addr;
	logic                          addr_zero;
	logic                          step_write;
	cfs_pkg::cfs_quad_t            quad_d;
	logic [SAMPLE_BITS-2:0]        rom_w [TAB_N];

	// Scale the 32-bit step pattern to the accumulator width
	generate
		if (PHASE_BITS > cfs_pkg::STEP_BITS) begin : g_step_wide
			assign step_scaled = {step_q, (PHASE_BITS - cfs_pkg::STEP_BITS)'(0)};
		end else if (PHASE_BITS == cfs_pkg::STEP_BITS) begin : g_step_same
			assign step_scaled = step_q;
		end else begin : g_step_narrow
			assign step_scaled = step_q[cfs_pkg::STEP_BITS-1 -: PHASE_BITS];
		end
	endgenerate

	// Decode register writes
	always_comb begin
		step_write = 1'b0;
		unique case (cfs_pkg::cfs_reg_t'(cfg_index))
			cfs_pkg::REG_PHASE_STEP: step_write = cfg_valid;
			cfs_pkg::REG_KEEP_PHASE: step_write = 1'b0;
			default:                 step_write = 1'b0;
		endcase
	end

	// Hold tuning registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			keep_q <= 1'b0;
		end else if (cfg_valid) begin
			if (step_write) begin
				step_q <= cfg_data[cfs_pkg::STEP_BITS-1:0];
			end else begin
				keep_q <= cfg_data[0];
			end
		end
	end

	// Advance phase per accepted sample; a retune clears it unless kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (step_write && !keep_q) begin
			phase_q <= '0;
		end else if (adv) begin
			phase_q <= phase_q + step_scaled;
		end
	end

	// Fill the table after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q <= '0;
		end else if (!fill_done) begin
			fill_cnt_q <= fill_cnt_q + 1'b1;
		end
	end

	assign fill_done = fill_cnt_q[TABLE_ADDR_BITS];

	// Fixed table contents, evaluated at elaboration
	generate
		for (genvar g = 0; g < TAB_N; g++) begin : g_rom
			assign rom_w[g] = (SAMPLE_BITS - 1)'(cfs_pkg::table_entry(32'(g),
				TABLE_ADDR_BITS, SAMPLE_BITS));
		end
	endgenerate

	// Split phase into quadrant and table address for sine and cosine
	always_comb begin
		idx       = phase_q[PHASE_BITS-1 -: IDX_BITS];
		quad_sin  = idx[IDX_BITS-1:TABLE_ADDR_BITS];
		quad_cos  = quad_sin + 2'd1;
		addr_fwd  = idx[TABLE_ADDR_BITS-1:0];
		addr_rev  = TABLE_ADDR_BITS'(0) - addr_fwd;
		addr_zero = (addr_fwd == '0);
		sin_addr  = quad_sin[0] ? addr_rev : addr_fwd;
		cos_addr  = quad_cos[0] ? addr_rev : addr_fwd;
		quad_d.sin_neg  = quad_sin[1];
		quad_d.sin_full = quad_sin[0] && addr_zero;
		quad_d.cos_neg  = quad_cos[1];
		quad_d.cos_full = quad_cos[0] && addr_zero;
	end

	// Register quadrant decode alongside the table read
	always_ff @(posedge clk) begin
		quad_s1 <= quad_d;
	end

	cfs_ram #(
		.WIDTH (SAMPLE_BITS - 1),
		.DEPTH (TAB_N)
	) u_table (
		.clk     (clk),
		.we      (!fill_done),
		.waddr   (fill_cnt_q[TABLE_ADDR_BITS-1:0]),
		.wdata   (rom_w[fill_cnt_q[TABLE_ADDR_BITS-1:0]]),
		.raddr_a (sin_addr),
		.rdata_a (sin_mag_s1),
		.raddr_b (cos_addr),
		.rdata_b (cos_mag_s1)
	);

endmodule

@@ rtl/cfs_mixer.sv @@
// Complex mixer: signed phasor, registered products, rounding and saturation.
`timescale 1ns / 1ps

module cfs_mixer #(
	parameter int SAMPLE_BITS = cfs_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic signed [SAMPLE_BITS-1:0] in_i_s1,
	input  logic signed [SAMPLE_BITS-1:0] in_q_s1,
	input  logic        [SAMPLE_BITS-2:0] sin_mag_s1,
	input  logic        [SAMPLE_BITS-2:0] cos_mag_s1,
	input  cfs_pkg::cfs_quad_t            quad_s1,
	output logic signed [SAMPLE_BITS-1:0] out_i,
	output logic signed [SAMPLE_BITS-1:0] out_q
);

	localparam int PROD_BITS = 2 * SAMPLE_BITS;
	localparam int SUM_BITS  = 2 * SAMPLE_BITS + 1;
	localparam logic [SAMPLE_BITS-2:0] AMP = '1;
	localparam logic signed [SUM_BITS-1:0] HALF  = SUM_BITS'(64'd1 << (SAMPLE_BITS - 2));
	localparam logic signed [SUM_BITS-1:0] MAX_V = SUM_BITS'(AMP);
	localparam logic signed [SUM_BITS-1:0] MIN_V = -MAX_V - SUM_BITS'(1);

	logic        [SAMPLE_BITS-2:0] sin_m;
	logic        [SAMPLE_BITS-2:0] cos_m;
	logic signed [SAMPLE_BITS-1:0] sin_v;
	logic signed [SAMPLE_BITS-1:0] cos_v;
	logic signed [PROD_BITS-1:0]   p_ic_s2;
	logic signed [PROD_BITS-1:0]   p_qs_s2;
	logic signed [PROD_BITS-1:0]   p_is_s2;
	logic signed [PROD_BITS-1:0]   p_qc_s2;
	logic signed [SUM_BITS-1:0]    sum_i;
	logic signed [SUM_BITS-1:0]    sum_q;
	logic signed [SUM_BITS-1:0]    rnd_i;
	logic signed [SUM_BITS-1:0]    rnd_q;

	// Build the signed phasor; a quarter-turn point takes full amplitude
	always_comb begin
		sin_m = quad_s1.sin_full ? AMP : sin_mag_s1;
		cos_m = quad_s1.cos_full ? AMP : cos_mag_s1;
		sin_v = quad_s1.sin_neg ? -$signed({1'b0, sin_m}) : $signed({1'b0, sin_m});
		cos_v = quad_s1.cos_neg ? -$signed({1'b0, cos_m}) : $signed({1'b0, cos_m});
	end

	// Register the four partial products
	always_ff @(posedge clk) begin
		p_ic_s2 <= PROD_BITS'(in_i_s1) * PROD_BITS'(cos_v);
		p_qs_s2 <= PROD_BITS'(in_q_s1) * PROD_BITS'(sin_v);
		p_is_s2 <= PROD_BITS'(in_i_s1) * PROD_BITS'(sin_v);
		p_qc_s2 <= PROD_BITS'(in_q_s1) * PROD_BITS'(cos_v);
	end

	// Combine, round half up, then clip to the sample range
	always_comb begin
		sum_i = SUM_BITS'(p_ic_s2) - SUM_BITS'(p_qs_s2);
		sum_q = SUM_BITS'(p_is_s2) + SUM_BITS'(p_qc_s2);
		rnd_i = (sum_i + HALF) >>> (SAMPLE_BITS - 1);
		rnd_q = (sum_q + HALF) >>> (SAMPLE_BITS - 1);
		if (rnd_i > MAX_V) begin
			out_i = SAMPLE_BITS'(MAX_V);
		end else if (rnd_i < MIN_V) begin
			out_i = SAMPLE_BITS'(MIN_V);
		end else begin
			out_i = SAMPLE_BITS'(rnd_i);
		end
		if (rnd_q > MAX_V) begin
			out_q = SAMPLE_BITS'(MAX_V);
		end else if (rnd_q < MIN_V) begin
			out_q = SAMPLE_BITS'(MIN_V);
		end else begin
			out_q = SAMPLE_BITS'(rnd_q);
		end
	end

endmodule

@@ rtl/cfs_fifo.sv @@
// Small result queue that decouples the mixer pipeline from output backpressure.
`timescale 1ns / 1ps

module cfs_fifo #(
	parameter int WIDTH = 33
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic [WIDTH-1:0]                  push_data,
	input  logic                              pop,
	output logic [WIDTH-1:0]                  pop_data,
	output logic                              not_empty,
	output logic [cfs_pkg::FIFO_LVL_BITS-1:0] level
);

	logic [WIDTH-1:0]                  mem_q [cfs_pkg::FIFO_DEPTH];
	logic [cfs_pkg::FIFO_PTR_BITS-1:0] head_q;
	logic [cfs_pkg::FIFO_PTR_BITS-1:0] tail_q;
	logic [cfs_pkg::FIFO_LVL_BITS-1:0] level_q;
	logic                              do_pop;

	assign do_pop    = pop && not_empty;
	assign not_empty = (level_q != '0);
	assign level     = level_q;
	assign pop_data  = mem_q[head_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= push_data;
		end
	end

	// Advance pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + 1'b1;
			end
			if (do_pop) begin
				head_q <= head_q + 1'b1;
			end
			level_q <= level_q + cfs_pkg::FIFO_LVL_BITS'(push)
				- cfs_pkg::FIFO_LVL_BITS'(do_pop);
		end
	end

endmodule

@@ rtl/complex_frequency_shifter.sv @@
// Path to m_axis: registered input and table read, registered products, rounding, result queue.
// Throughput: one sample per cycle when not stalled; 4-entry queue credit count sets s_axis_tready.
// Reset: asynchronous, active low; clears phase, step, keep_phase and all valid state.
// After reset the sine table is filled, one entry per cycle, with s_axis_tready low until
// every entry is written; configuration writes are taken meanwhile.
`timescale 1ns / 1ps
`include "complex_frequency_shifter_assert.svh"

module complex_frequency_shifter #(
	parameter int SAMPLE_BITS     = cfs_pkg::SAMPLE_BITS_DEF,
	parameter int PHASE_BITS      = cfs_pkg::PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = cfs_pkg::TABLE_ADDR_BITS_DEF,
	localparam int TDATA_BITS     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [TDATA_BITS-1:0]              s_axis_tdata,  // in_i, in_q, zero pad
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [TDATA_BITS-1:0]              m_axis_tdata,  // out_i, out_q, zero pad
	output logic                               m_axis_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [cfs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int ENTRY_BITS = 2 * SAMPLE_BITS + 1;

	logic                              in_fire;
	logic                              out_fire;
	logic                              fill_done;
	logic signed [SAMPLE_BITS-1:0]     in_i_s1;
	logic signed [SAMPLE_BITS-1:0]     in_q_s1;
	logic                              last_s1;
	logic                              valid_s1;
	logic                              last_s2;
	logic                              valid_s2;
	logic [SAMPLE_BITS-2:0]            sin_mag_s1;
	logic [SAMPLE_BITS-2:0]            cos_mag_s1;
	cfs_pkg::cfs_quad_t                quad_s1;
	logic signed [SAMPLE_BITS-1:0]     out_i;
	logic signed [SAMPLE_BITS-1:0]     out_q;
	logic [ENTRY_BITS-1:0]             head_entry;
	logic [cfs_pkg::FIFO_LVL_BITS-1:0] cnt_q;
	logic [cfs_pkg::FIFO_LVL_BITS-1:0] fifo_level;

	assign cfg_ready = 1'b1;
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign out_fire  = m_axis_tvalid && m_axis_tready;

	// Accept while the table is ready and a queue slot is reserved
	assign s_axis_tready = fill_done
		&& (cnt_q != cfs_pkg::FIFO_LVL_BITS'(cfs_pkg::FIFO_DEPTH));

	// Count samples in flight or queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + cfs_pkg::FIFO_LVL_BITS'(in_fire)
				- cfs_pkg::FIFO_LVL_BITS'(out_fire);
		end
	end

	// Capture the sample
	always_ff @(posedge clk) begin
		in_i_s1 <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
		in_q_s1 <= $signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
		last_s1 <= s_axis_tlast;
		last_s2 <= last_s1;
	end

	// Track valid through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
			valid_s2 <= valid_s1;
		end
	end

	cfs_nco #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_nco (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.adv        (in_fire),
		.fill_done  (fill_done),
		.sin_mag_s1 (sin_mag_s1),
		.cos_mag_s1 (cos_mag_s1),
		.quad_s1    (quad_s1)
	);

	cfs_mixer #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mixer (
		.clk        (clk),
		.in_i_s1    (in_i_s1),
		.in_q_s1    (in_q_s1),
		.sin_mag_s1 (sin_mag_s1),
		.cos_mag_s1 (cos_mag_s1),
		.quad_s1    (quad_s1),
		.out_i      (out_i),
		.out_q      (out_q)
	);

	cfs_fifo #(
		.WIDTH (ENTRY_BITS)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s2),
		.push_data ({last_s2, out_q, out_i}),
		.pop       (m_axis_tready),
		.pop_data  (head_entry),
		.not_empty (m_axis_tvalid),
		.level     (fifo_level)
	);

	// Drive the output transaction from the queue head
	assign m_axis_tdata = TDATA_BITS'(head_entry[2*SAMPLE_BITS-1:0]);
	assign m_axis_tlast = head_entry[ENTRY_BITS-1];

	// Checks
	`CFS_NEVER(a_credit_bound, cnt_q > cfs_pkg::FIFO_LVL_BITS'(cfs_pkg::FIFO_DEPTH))
	`CFS_NEVER(a_push_full, valid_s2 && (fifo_level == cfs_pkg::FIFO_LVL_BITS'(cfs_pkg::FIFO_DEPTH)))
	`CFS_CHECK(a_level_covered, fifo_level <= cnt_q)

endmodule

@@ test/tb_complex_frequency_shifter.sv @@
// Self-checking testbench for complex_frequency_shifter: stream traffic, retunes, scoreboard.
`timescale 1ns / 1ps

module tb_complex_frequency_shifter;

	typedef struct {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               last;
	} mixed_sample_t;

	// Mixer prediction: phase accumulator, quarter-wave table, expected output queue
	class mixer_model;
		int            quarter_sine[1024];
		bit [31:0]     phase_acc;
		bit [31:0]     phase_step;
		bit            keep_phase;
		mixed_sample_t expected_mix[$];
		int            mismatch_count;
		int            samples_in;
		int            results_out;

		function new();
			longint unsigned x;
			longint unsigned x2;
			longint unsigned t;
			longint unsigned s;
			longint unsigned v;
			// Build the table with a Q30 Taylor series of sin(pi/2 * k / 1024)
			for (int k = 0; k < 1024; k++) begin
				x = (64'(k) * 64'd1686629713 + 64'd512) >> 10;
				x2 = (x * x) >> 30;
				t = 64'd1 << 30;
				for (int n = 8; n >= 1; n--) begin
					t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'((2 * n) * (2 * n + 1));
				end
				s = (x * t) >> 30;
				v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
				if (v > 64'd32767) begin
					v = 64'd32767;
				end
				quarter_sine[k] = int'(v);
			end
			phase_acc = '0;
			phase_step = '0;
			keep_phase = 1'b0;
		endfunction

		// Signed sine at a 12-bit phase index (two quadrant bits over ten address bits)
		function longint sine_of(bit [11:0] idx);
			bit [9:0] addr;
			longint   mag;
			addr = idx[9:0];
			if (idx[10]) begin
				// table holds no quarter-turn entry; use full amplitude there
				mag = (addr == 10'd0) ? 64'sd32767 : longint'(quarter_sine[1024 - int'(addr)]);
			end else begin
				mag = longint'(quarter_sine[addr]);
			end
			return idx[11] ? -mag : mag;
		endfunction

		// Round half up, then clip to 16 bits
		function logic signed [15:0] round_clip(longint v);
			longint r;
			r = (v + 64'sd16384) >>> 15;
			if (r > 64'sd32767) begin
				r = 64'sd32767;
			end
			if (r < -64'sd32768) begin
				r = -64'sd32768;
			end
			return r[15:0];
		endfunction

		function void write_reg(cfs_pkg::cfs_reg_t idx, logic [31:0] value);
			case (idx)
				cfs_pkg::REG_PHASE_STEP: begin
					phase_step = value;
					if (!keep_phase) begin
						phase_acc = '0;
					end
				end
				cfs_pkg::REG_KEEP_PHASE: begin
					keep_phase = value[0];
				end
				default: begin
				end
			endcase
		endfunction

		// Predict the result of one accepted input transaction
		function void note_sample(logic signed [15:0] si, logic signed [15:0] sq, logic last);
			bit [11:0]     idx;
			longint        s;
			longint        c;
			mixed_sample_t res;
			idx = phase_acc[31:20];
			s = sine_of(idx);
			c = sine_of(idx + 12'd1024);
			res.re = round_clip(longint'(si) * c - longint'(sq) * s);
			res.im = round_clip(longint'(si) * s + longint'(sq) * c);
			res.last = last;
			expected_mix.push_back(res);
			phase_acc = phase_acc + phase_step;
			samples_in++;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatch_count++;
		endtask

		// Compare one output transaction with the oldest prediction
		task check_result(logic [31:0] data, logic last);
			mixed_sample_t want;
			if (expected_mix.size() == 0) begin
				report($sformatf("unexpected result data=%h last=%b", data, last));
			end else begin
				want = expected_mix.pop_front();
				results_out++;
				if (data[15:0] !== want.re) begin
					report($sformatf("result %0d out_i got %0d want %0d", results_out,
						$signed(data[15:0]), want.re));
				end
				if (data[31:16] !== want.im) begin
					report($sformatf("result %0d out_q got %0d want %0d", results_out,
						$signed(data[31:16]), want.im));
				end
				if (last !== want.last) begin
					report($sformatf("result %0d out_last got %b want %b", results_out,
						last, want.last));
				end
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // in_i, in_q
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;       // out_i, out_q
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [cfs_pkg::CFG_INDEX_BITS-1:0] cfg_index = cfs_pkg::REG_PHASE_STEP;
	logic [cfs_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

	mixer_model sb;
	int         send_idle_pct = 0;
	int         ready_stall_pct = 0;
	int         directed_count;

	complex_frequency_shifter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on run time
	initial begin
		#5_000_000;
		$display("[complex_frequency_shifter] ERROR");
		$finish;
	end

	// Receive side: check each output transaction, stall at random
	initial begin
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata, m_axis_tlast);
			end
			m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	// Send one sample; valid stays high when the next one follows without a gap
	task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {im, re};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(re, im, last);
	endtask

	// Write one register; caller lowers cfg_valid after the last write
	task automatic cfg_write(cfs_pkg::cfs_reg_t idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, value);
	endtask

	task automatic retune(logic keep, logic [31:0] step);
		cfg_write(cfs_pkg::REG_KEEP_PHASE, {31'b0, keep});
		cfg_write(cfs_pkg::REG_PHASE_STEP, step);
		cfg_valid <= 1'b0;
	endtask

	// Hold the sender until every predicted result has come, then let the pipe settle
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_mix.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly well-formed blocks closed by tlast, some lone samples with random tlast
	task automatic random_traffic(int count);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(4) != 0) begin
				len = $urandom_range(1, 16);
				for (int j = 0; j < len; j++) begin
					send_sample(rand_sample(), rand_sample(), j == len - 1);
				end
				sent += len;
			end else begin
				send_sample(rand_sample(), rand_sample(), 1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Phase zero: unit phasor, extremes and a rounding tie
		retune(1'b0, 32'h0000_0000);
		send_sample(16'sd32767, -16'sd32768, 1'b0);
		send_sample(-16'sd32768, 16'sd32767, 1'b0);
		send_sample(16'sd0, 16'sd0, 1'b0);
		send_sample(-16'sd16384, 16'sd16384, 1'b0);
		send_sample(16'sd1, -16'sd1, 1'b1);
		drain_results();

		// Quarter-turn steps hit the points with no table entry
		retune(1'b0, 32'h4000_0000);
		send_sample(16'sd32767, -16'sd32768, 1'b0);
		send_sample(-16'sd32768, -16'sd32768, 1'b0);
		send_sample(16'sd12345, -16'sd23456, 1'b0);
		send_sample(-16'sd1, 16'sd1, 1'b1);
		send_sample(16'sd32767, 16'sd32767, 1'b0);
		send_sample(-16'sd32768, 16'sd32767, 1'b0);
		send_sample(16'sd0, -16'sd32768, 1'b0);
		send_sample(16'sd32767, 16'sd0, 1'b1);
		drain_results();

		// Eighth-turn steps drive the products into saturation
		retune(1'b0, 32'h2000_0000);
		send_sample(16'sd32767, -16'sd32768, 1'b0);
		send_sample(-16'sd32768, 16'sd32767, 1'b0);
		send_sample(-16'sd32768, -16'sd32768, 1'b0);
		send_sample(16'sd32767, 16'sd32767, 1'b0);
		send_sample(16'sd32767, -16'sd32768, 1'b0);
		send_sample(-16'sd32768, 16'sd32767, 1'b0);
		send_sample(-16'sd32768, -16'sd32768, 1'b0);
		send_sample(16'sd32767, 16'sd32767, 1'b1);
		drain_results();
		directed_count = sb.samples_in;

		// Largest positive step, no idling
		retune(1'b0, 32'h7fff_ffff);
		random_traffic(100);
		drain_results();

		// Most negative step with phase kept, sender mostly idle
		send_idle_pct = 85;
		retune(1'b1, 32'h8000_0000);
		random_traffic(100);
		drain_results();

		// Clear keep_phase alone: phase carries on; receiver mostly stalled
		send_idle_pct = 0;
		ready_stall_pct = 85;
		cfg_write(cfs_pkg::REG_KEEP_PHASE, 32'd0);
		cfg_valid <= 1'b0;
		random_traffic(50);
		drain_results();
		random_traffic(50);
		drain_results();

		// Random step with phase kept, both sides idling
		send_idle_pct = 22;
		ready_stall_pct = 22;
		retune(1'b1, $urandom);
		random_traffic(100);
		drain_results();

		$display("covered %0d directed and %0d random samples, %0d results checked",
			directed_count, sb.samples_in - directed_count, sb.results_out);
		$display("steps: zero, quarter, eighth, both extremes, random; keep_phase on and off");
		if (sb.mismatch_count == 0) begin
			$display("[complex_frequency_shifter] OK");
		end else begin
			$display("[complex_frequency_shifter] ERROR");
		end
		$finish;
	end

endmodule
